[design/lfuc_pkg.sv]
// shared types and constants for the lfu cache with lru tie-break
package lfuc_pkg;

   localparam int DATA_W = 32;
   localparam int CSR_W  = 5;

   localparam logic [CSR_W-1:0]         CAP_RESET  = 5'd16;
   localparam logic                     OP_PUT     = 1'b1;
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] lookup_key;
      logic signed [DATA_W-1:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
      logic signed [DATA_W-1:0] evicted_key;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

[design/lfuc_ctrl.sv]
// controller state machine: accept, scan, commit and response handshake
module lfuc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lfuc_pkg::dp_cmd_type    cmd,
   input  lfuc_pkg::dp_status_type status
);
   import lfuc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      commit_ok;

   // output register is free or being emptied this cycle
   assign commit_ok  = !rsp_valid_ff || rsp_ready;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.commit = (state_ff == ST_COMMIT) && commit_ok;

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (commit_ok) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // result register fills at commit and empties when taken
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

[design/lfuc_datapath.sv]
// datapath: entry memory, scan pipeline, victim search, commit and response register
module lfuc_datapath #(
   parameter int MAX_ENTRIES = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfuc_pkg::req_item_type        req_item,
   input  logic                          csr_valid,
   input  logic [lfuc_pkg::CSR_W-1:0]    csr_wdata,
   input  lfuc_pkg::dp_cmd_type          cmd,
   output lfuc_pkg::dp_status_type       status,
   output lfuc_pkg::rsp_item_type        rsp_item
);
   import lfuc_pkg::*;

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CSR_W) ? OCC_W : CSR_W;
   localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(MAX_ENTRIES - 1);
   localparam logic [CMP_W-1:0]      MAX_CAP   = CMP_W'(MAX_ENTRIES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
      logic [COUNT_BITS-1:0]    count;
      logic [RANK_W-1:0]        rank;
   } entry_type;

   // rank fix-up left over from the previous transaction
   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_TOUCH,
      PEND_INSERT
   } pend_type;

   entry_type mem [MAX_ENTRIES];

   req_item_type           req_ff;
   logic                   rd_go_ff;
   logic                   rd_go_in;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   proc_vld_ff;
   logic [IDX_W-1:0]       proc_idx_ff;
   entry_type              rd_word_ff;

   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [MAX_ENTRIES-1:0] valid_in;
   logic [OCC_W-1:0]       occ_ff;
   logic [CSR_W-1:0]       capacity_ff;

   pend_type               pend_mode_ff;
   logic [RANK_W-1:0]      pend_rank_ff;
   logic [IDX_W-1:0]       pend_slot_ff;
   logic                   pend_evict_ff;

   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic signed [DATA_W-1:0] hit_val_ff;
   logic [COUNT_BITS-1:0]  hit_count_ff;
   logic [RANK_W-1:0]      hit_rank_ff;

   logic                   vic_found_ff;
   logic [IDX_W-1:0]       vic_idx_ff;
   logic [COUNT_BITS-1:0]  vic_count_ff;
   logic [RANK_W-1:0]      vic_rank_ff;
   logic signed [DATA_W-1:0] vic_key_ff;

   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;

   rsp_item_type           rsp_item_ff;
   rsp_item_type           rsp_item_in;

   logic [RANK_W-1:0]      rank_adj;
   logic                   proc_take;
   logic                   key_match;
   logic                   better;

   logic [CMP_W-1:0]       cap_eff;
   logic                   is_put;
   logic                   cap_zero;
   logic                   touch_op;
   logic                   insert_op;
   logic                   do_evict;
   logic [IDX_W-1:0]       ins_slot;
   logic [COUNT_BITS-1:0]  bumped;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   entry_type              mem_wdata;

   // scan address sequencer
   always_comb begin
      if (cmd.load) begin
         rd_go_in = 1'b1;
      end else if (rd_go_ff && (rd_idx_ff == LAST_IDX)) begin
         rd_go_in = 1'b0;
      end else begin
         rd_go_in = rd_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_go_ff    <= 1'b0;
         proc_vld_ff <= 1'b0;
      end else begin
         rd_go_ff    <= rd_go_in;
         proc_vld_ff <= rd_go_ff;
      end
   end

   // request capture, address count and registered memory read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_item;
         rd_idx_ff <= '0;
      end else if (rd_go_ff && (rd_idx_ff != LAST_IDX)) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
      if (rd_go_ff) begin
         rd_word_ff  <= mem[rd_idx_ff];
         proc_idx_ff <= rd_idx_ff;
      end
   end

   // apply the pending rank fix-up to the entry being scanned
   always_comb begin
      rank_adj = rd_word_ff.rank;
      if (proc_idx_ff != pend_slot_ff) begin
         case (pend_mode_ff)
            PEND_TOUCH: begin
               if (rd_word_ff.rank < pend_rank_ff) begin
                  rank_adj = rd_word_ff.rank + RANK_W'(1);
               end
            end
            PEND_INSERT: begin
               // for entries older than an evicted victim, its removal cancels the insert shift
               if (!(pend_evict_ff && (rd_word_ff.rank > pend_rank_ff))) begin
                  rank_adj = rd_word_ff.rank + RANK_W'(1);
               end
            end
            default: begin
               rank_adj = rd_word_ff.rank;
            end
         endcase
      end
   end

   assign proc_take = proc_vld_ff && valid_ff[proc_idx_ff];
   assign key_match = (rd_word_ff.key == req_ff.lookup_key);
   // lowest count wins, equal counts go to the oldest
   assign better    = !vic_found_ff || (rd_word_ff.count < vic_count_ff) ||
                      ((rd_word_ff.count == vic_count_ff) && (rank_adj > vic_rank_ff));

   assign status.scan_done = proc_vld_ff && (proc_idx_ff == LAST_IDX);

   // hit, victim and free slot tracking
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff        <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (proc_vld_ff) begin
         if (valid_ff[proc_idx_ff]) begin
            if (key_match) begin
               hit_ff       <= 1'b1;
               hit_idx_ff   <= proc_idx_ff;
               hit_val_ff   <= rd_word_ff.value;
               hit_count_ff <= rd_word_ff.count;
               hit_rank_ff  <= rank_adj;
            end
            if (better) begin
               vic_found_ff <= 1'b1;
               vic_idx_ff   <= proc_idx_ff;
               vic_count_ff <= rd_word_ff.count;
               vic_rank_ff  <= rank_adj;
               vic_key_ff   <= rd_word_ff.key;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= proc_idx_ff;
         end
      end
   end

   // commit decode
   always_comb begin
      if (CMP_W'(capacity_ff) > MAX_CAP) begin
         cap_eff = MAX_CAP;
      end else begin
         cap_eff = CMP_W'(capacity_ff);
      end
   end

   assign is_put    = (req_ff.req_type == OP_PUT);
   assign cap_zero  = (cap_eff == '0);
   assign touch_op  = hit_ff && (!is_put || !cap_zero);
   assign insert_op = is_put && !cap_zero && !hit_ff;
   assign do_evict  = insert_op && (CMP_W'(occ_ff) >= cap_eff);
   assign ins_slot  = (do_evict && (!free_found_ff || (vic_idx_ff < free_idx_ff))) ?
                      vic_idx_ff : free_idx_ff;
   assign bumped    = (hit_count_ff == COUNT_MAX) ? hit_count_ff :
                      hit_count_ff + COUNT_BITS'(1);

   // response of this transaction
   always_comb begin
      rsp_item_in.found       = hit_ff;
      rsp_item_in.evicted     = do_evict;
      rsp_item_in.evicted_key = do_evict ? vic_key_ff : '0;
      if (is_put) begin
         rsp_item_in.read_value = '0;
      end else if (hit_ff) begin
         rsp_item_in.read_value = hit_val_ff;
      end else begin
         rsp_item_in.read_value = MISS_VALUE;
      end
   end

   // memory write port: target entry at commit, rank write-back during scan
   always_comb begin
      mem_we         = 1'b0;
      mem_waddr      = proc_idx_ff;
      mem_wdata      = rd_word_ff;
      mem_wdata.rank = rank_adj;
      if (cmd.commit) begin
         mem_we          = touch_op || insert_op;
         mem_wdata.key   = req_ff.lookup_key;
         mem_wdata.value = req_ff.write_value;
         mem_wdata.rank  = '0;
         if (touch_op) begin
            mem_waddr       = hit_idx_ff;
            mem_wdata.count = bumped;
            if (!is_put) begin
               mem_wdata.value = hit_val_ff;
            end
         end else begin
            mem_waddr       = ins_slot;
            mem_wdata.count = COUNT_BITS'(1);
         end
      end else if (proc_take) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // valid bits after this cycle's commit
   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && insert_op) begin
         if (do_evict) begin
            valid_in[vic_idx_ff] = 1'b0;
         end
         valid_in[ins_slot] = 1'b1;
      end
   end

   // valid bits, occupancy, capacity and pending fix-up
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         pend_mode_ff <= PEND_NONE;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid) begin
            capacity_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            if (touch_op) begin
               pend_mode_ff <= PEND_TOUCH;
            end else if (insert_op) begin
               pend_mode_ff <= PEND_INSERT;
            end else begin
               pend_mode_ff <= PEND_NONE;
            end
            if (insert_op && !do_evict) begin
               occ_ff <= occ_ff + OCC_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pend_rank_ff  <= touch_op ? hit_rank_ff : vic_rank_ff;
         pend_slot_ff  <= touch_op ? hit_idx_ff : ins_slot;
         pend_evict_ff <= do_evict;
         rsp_item_ff   <= rsp_item_in;
      end
   end

   assign rsp_item = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy differs from number of valid entries");

   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!proc_vld_ff && !rd_go_ff))
      else $error("commit while scan still running");

   a_state_only_at_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> ($stable(occ_ff) && $stable(valid_ff)))
      else $error("entry set changed outside commit");

   a_hit_is_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && hit_ff) |-> valid_ff[hit_idx_ff])
      else $error("hit on an entry that is not valid");
`endif

endmodule

[design/lfu_cache_lru_tiebreak.sv]
// top level of the lfu cache with lru tie-break
//
// req channel (req_valid/req_ready, req_item) carries one get or put
// transaction; rsp channel (rsp_valid/rsp_ready, rsp_item) returns exactly
// one result per request, in order. csr channel writes the capacity
// register; csr_ready is always high and writes are meant for idle time.
// Each request reads every entry of the entry memory once through its single
// read port before its commit step, and the next request is accepted only
// after that commit. The result is registered in the output register at
// commit. Rank changes of one transaction are written back during the scan
// of the next one.
// Reset clears all valid bits, occupancy and the pending rank fix-up, and
// sets capacity to 16; no memory clearing pass is needed.
// The result sits in an output register, so a new request is taken while
// it waits; when the receiver stalls, the following result is held back
// in its commit step until the output register is taken.
module lfu_cache_lru_tiebreak #(
   parameter int MAX_ENTRIES = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lfuc_pkg::req_item_type     req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lfuc_pkg::rsp_item_type     rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lfuc_pkg::CSR_W-1:0] csr_wdata
);
   import lfuc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // capacity register is always writable
   assign csr_ready = 1'b1;

   lfuc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lfuc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule
